// File: src/rvc_pkg.sv
// Shared definitions for the rectangle view culling block.
// Holds parameter defaults, register indexes and reset values, the stage advance struct and the sum width function.
// No dependencies; rvc_row, the top level and the testbench import this package.
package rvc_pkg;

	// Default fixed point format of coordinates, gains and offsets.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Register indexes on the configuration port (byte address is 8 times the index).
	typedef enum logic [2:0] {
		REG_X_GAINS  = 3'd0,
		REG_X_OFFSET = 3'd1,
		REG_Y_GAINS  = 3'd2,
		REG_Y_OFFSET = 3'd3,
		REG_W_GAINS  = 3'd4,
		REG_W_OFFSET = 3'd5
	} rvc_reg_t;

	// Register reset values: identity x and y rows, w fixed at one.
	localparam logic [63:0] X_GAINS_RST  = 64'h0001_0000_0000_0000;
	localparam logic [31:0] X_OFFSET_RST = 32'h0000_0000;
	localparam logic [63:0] Y_GAINS_RST  = 64'h0000_0000_0001_0000;
	localparam logic [31:0] Y_OFFSET_RST = 32'h0000_0000;
	localparam logic [63:0] W_GAINS_RST  = 64'h0000_0000_0000_0000;
	localparam logic [31:0] W_OFFSET_RST = 32'h0001_0000;

	// Load enables of the pipeline stages inside a row unit.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} rvc_adv_t;

	// Width of the row sums: products, doubled centre term, size terms,
	// scaled offset and the later w +/- x sums all fit without overflow.
	function automatic int rvc_acc_width(input int cw, input int fb);
		int wide;
		wide = (2 * cw > cw + fb) ? 2 * cw : cw + fb;
		return wide + 4;
	endfunction

endpackage

// File: src/rvc_row.sv
// One row of the view-projection matrix evaluated at the four rectangle corners.
// Three register stages: products, centre sum with offset, corner sums.
// Depends on rvc_pkg for the advance struct and the sum width.
module rvc_row import rvc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  rvc_adv_t                 adv,
	input  logic [63:0]              gains,
	input  logic [31:0]              offset,
	input  logic signed [COORD_WIDTH-1:0] cx_s1,
	input  logic signed [COORD_WIDTH-1:0] cy_s1,
	input  logic signed [COORD_WIDTH-1:0] fw_s1,
	input  logic signed [COORD_WIDTH-1:0] fh_s1,
	output logic signed [rvc_acc_width(COORD_WIDTH, FRAC_BITS)-1:0] corner_s4 [4]
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * COORD_WIDTH;
	localparam int AW = rvc_acc_width(COORD_WIDTH, FRAC_BITS);

	logic signed [CW-1:0] gx;
	logic signed [CW-1:0] gy;
	logic signed [CW-1:0] off;

	logic signed [PW-1:0] p_cx_s2;
	logic signed [PW-1:0] p_cy_s2;
	logic signed [PW-1:0] p_fw_s2;
	logic signed [PW-1:0] p_fh_s2;

	logic signed [AW-1:0] base_s3;
	logic signed [AW-1:0] tw_s3;
	logic signed [AW-1:0] th_s3;

	// Gains and offset use the low coordinate bits of each register half.
	assign gx  = gains[32 +: CW];
	assign gy  = gains[0 +: CW];
	assign off = offset[CW-1:0];

	// Stage 2: the four products of this row.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p_cx_s2 <= PW'(gx) * PW'(cx_s1);
			p_cy_s2 <= PW'(gy) * PW'(cy_s1);
			p_fw_s2 <= PW'(gx) * PW'(fw_s1);
			p_fh_s2 <= PW'(gy) * PW'(fh_s1);
		end
	end

	// Stage 3: doubled centre term plus the offset scaled to the same point.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			base_s3 <= ((AW'(p_cx_s2) + AW'(p_cy_s2)) <<< 1) + (AW'(off) <<< (FRAC_BITS + 1));
			tw_s3   <= AW'(p_fw_s2);
			th_s3   <= AW'(p_fh_s2);
		end
	end

	// Stage 4: the corners, full size added or taken away on each axis.
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			corner_s4[0] <= base_s3 - tw_s3 - th_s3;
			corner_s4[1] <= base_s3 + tw_s3 - th_s3;
			corner_s4[2] <= base_s3 + tw_s3 + th_s3;
			corner_s4[3] <= base_s3 - tw_s3 + th_s3;
		end
	end

endmodule

// File: src/rect_view_cull_test.sv
// Top level of the rectangle view culling block: register port, input and output
// stream channels, pipeline control and the final overlap test.
// Depends on rvc_pkg and rvc_row.

// One rectangle is accepted per clock cycle while no stalled output holds back the pipe.
// On its way to the result the item passes an input register, three stages inside
// each row unit (products, centre sum, corner sums), a stage of edge tests and the
// output register. Each stage holds its own valid bit, so a stalled output only holds
// back the items behind it while bubbles in the pipe are still filled. The matrix
// registers must be written only while the pipe is empty.
module rect_view_cull_test import rvc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// Register port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// Input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // center_x, center_y, full_width, full_height
	// Result items
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata   // visible, corners_in_front[2:0], zero padding
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = rvc_acc_width(COORD_WIDTH, FRAC_BITS);

	logic [63:0] x_gains_q;
	logic [31:0] x_offset_q;
	logic [63:0] y_gains_q;
	logic [31:0] y_offset_q;
	logic [63:0] w_gains_q;
	logic [31:0] w_offset_q;

	rvc_reg_t reg_idx;
	logic     reg_wr;

	logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
	logic en1, en2, en3, en4, en5, en_out;
	rvc_adv_t adv;

	logic signed [CW-1:0] cx_s1, cy_s1, fw_s1, fh_s1;
	logic signed [AW-1:0] x_s4 [4];
	logic signed [AW-1:0] y_s4 [4];
	logic signed [AW-1:0] w_s4 [4];

	logic [3:0] kept_s5, nl_s5, nr_s5, nb_s5, na_s5;
	logic       visible_q;
	logic [2:0] count_q;

	// Register writes and reads; the address selects by its index bits only.
	assign reg_idx = rvc_reg_t'(paddr[5:3]);
	assign reg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_gains_q  <= X_GAINS_RST;
			x_offset_q <= X_OFFSET_RST;
			y_gains_q  <= Y_GAINS_RST;
			y_offset_q <= Y_OFFSET_RST;
			w_gains_q  <= W_GAINS_RST;
			w_offset_q <= W_OFFSET_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_X_GAINS:  x_gains_q  <= pwdata;
				REG_X_OFFSET: x_offset_q <= pwdata[31:0];
				REG_Y_GAINS:  y_gains_q  <= pwdata;
				REG_Y_OFFSET: y_offset_q <= pwdata[31:0];
				REG_W_GAINS:  w_gains_q  <= pwdata;
				REG_W_OFFSET: w_offset_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_X_GAINS:  prdata = x_gains_q;
			REG_X_OFFSET: prdata = {32'd0, x_offset_q};
			REG_Y_GAINS:  prdata = y_gains_q;
			REG_Y_OFFSET: prdata = {32'd0, y_offset_q};
			REG_W_GAINS:  prdata = w_gains_q;
			REG_W_OFFSET: prdata = {32'd0, w_offset_q};
			default:      prdata = 64'd0;
		endcase
	end

	// A stage loads when it is empty or when the stage after it loads.
	assign en_out   = !out_valid_q || m_tready;
	assign en5      = !v5_q || en_out;
	assign en4      = !v4_q || en5;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign s_tready = en1;
	assign adv      = '{s2: en2, s3: en3, s4: en4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			v5_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)    v1_q        <= s_tvalid;
			if (en2)    v2_q        <= v1_q;
			if (en3)    v3_q        <= v2_q;
			if (en4)    v4_q        <= v3_q;
			if (en5)    v5_q        <= v4_q;
			if (en_out) out_valid_q <= v5_q;
		end
	end

	// Stage 1: input fields, low coordinate bits of each.
	always_ff @(posedge clk) begin
		if (en1) begin
			cx_s1 <= s_tdata[0 +: CW];
			cy_s1 <= s_tdata[32 +: CW];
			fw_s1 <= s_tdata[64 +: CW];
			fh_s1 <= s_tdata[96 +: CW];
		end
	end

	// Stages 2 to 4: the three matrix rows at every corner.
	rvc_row #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_x (
		.clk(clk), .adv(adv), .gains(x_gains_q), .offset(x_offset_q),
		.cx_s1(cx_s1), .cy_s1(cy_s1), .fw_s1(fw_s1), .fh_s1(fh_s1), .corner_s4(x_s4)
	);

	rvc_row #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_y (
		.clk(clk), .adv(adv), .gains(y_gains_q), .offset(y_offset_q),
		.cx_s1(cx_s1), .cy_s1(cy_s1), .fw_s1(fw_s1), .fh_s1(fh_s1), .corner_s4(y_s4)
	);

	rvc_row #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_w (
		.clk(clk), .adv(adv), .gains(w_gains_q), .offset(w_offset_q),
		.cx_s1(cx_s1), .cy_s1(cy_s1), .fw_s1(fw_s1), .fh_s1(fh_s1), .corner_s4(w_s4)
	);

	// Stage 5: per corner, whether it is in front and on the near side of each edge.
	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < 4; k++) begin
				logic front;
				logic signed [AW-1:0] xl, xr, yb, ya;
				front = !w_s4[k][AW-1] && (w_s4[k] != '0);
				xl    = x_s4[k] + w_s4[k];
				xr    = w_s4[k] - x_s4[k];
				yb    = y_s4[k] + w_s4[k];
				ya    = w_s4[k] - y_s4[k];
				kept_s5[k] <= front;
				nl_s5[k]   <= front && !xl[AW-1];
				nr_s5[k]   <= front && !xr[AW-1];
				nb_s5[k]   <= front && !yb[AW-1];
				na_s5[k]   <= front && !ya[AW-1];
			end
		end
	end

	// Output register: the box misses if no corner is kept or all kept corners lie beyond one edge.
	always_ff @(posedge clk) begin
		if (en_out) begin
			visible_q <= (|kept_s5) && (|nl_s5) && (|nr_s5) && (|nb_s5) && (|na_s5);
			count_q   <= 3'(kept_s5[0]) + 3'(kept_s5[1]) + 3'(kept_s5[2]) + 3'(kept_s5[3]);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, count_q, visible_q};

endmodule

// File: src/rvc_checker.sv
// Port-level checks for the rectangle view culling block, bound to its top level.
// Depends on rect_view_cull_test for the port list.
module rvc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [7:0]   m_tdata
);

	// No result is offered while reset is applied.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result offered during reset");

	// At most four corners can be in front.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] != 3'd5 && m_tdata[3:1] != 3'd6 && m_tdata[3:1] != 3'd7))
		else $error("corner count above four");

	// A visible rectangle has at least one corner in front.
	a_visible_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] != 3'd0))
		else $error("visible with no corner in front");

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	// With the output empty the block always takes a new item.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind rect_view_cull_test rvc_checker u_rvc_checker (.*);

// File: dv/tb_rect_view_cull_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rect_view_cull_test: rectangles in, visibility results out.
// Drives the stream and register ports and checks each result against hand-written values or an in-bench predictor.
// Depends on rvc_pkg and the block's RTL.
module tb_rect_view_cull_test;
	import rvc_pkg::*;

	localparam logic [31:0] FX_ZERO = 32'h0000_0000;
	localparam logic [31:0] FX_ONE  = 32'h0001_0000;
	localparam logic [31:0] FX_NEG1 = 32'hFFFF_0000;
	localparam logic [31:0] FX_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] FX_MIN  = 32'h8000_0000;
	localparam int          SPAN4   = 4 * 65536;
	localparam logic [2:0]  REG_UNUSED     = 3'd6;
	localparam int          ITEMS_PER_PHASE = 72;
	localparam int          WATCHDOG_LIMIT  = 2000;
	localparam int          TAIL_CYCLES     = 20;

	typedef enum int {MX_SCENE, MX_EXTREME, MX_NOISE, MX_RESET} matrix_mode_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] fw;
		logic signed [31:0] fh;
	} rect_t;

	typedef struct packed {
		logic       visible;
		logic [2:0] in_front;
	} cull_result_t;

	// One directed step: either a register write or a rectangle, with an
	// optional hand-written result.
	typedef struct packed {
		logic         is_write;
		logic [2:0]   reg_idx;
		logic [63:0]  reg_val;
		rect_t        rect;
		logic         typed;
		cull_result_t want;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [5:0]   paddr    = '0;
	logic [63:0]  pwdata   = '0;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;  // center_x, center_y, full_width, full_height
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [7:0]   m_tdata;        // visible, corners_in_front[2:0], zero padding

	// Predictor copy of the view-projection matrix.
	logic [63:0]  mat_x_gains = X_GAINS_RST;
	logic [31:0]  mat_x_off   = X_OFFSET_RST;
	logic [63:0]  mat_y_gains = Y_GAINS_RST;
	logic [31:0]  mat_y_off   = Y_OFFSET_RST;
	logic [63:0]  mat_w_gains = W_GAINS_RST;
	logic [31:0]  mat_w_off   = W_OFFSET_RST;

	cull_result_t pending_culls[$];
	dir_row_t     dir_table[$];
	int           fail_count  = 0;
	int           quiet_cycles = 0;
	int           stall_left  = 0;
	logic         rx_idling   = 1'b1;
	logic         tx_idling   = 1'b1;

	rect_view_cull_test i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One matrix row at one corner, exact, scaled by 2^(2*FRAC_BITS+1).
	function automatic logic signed [127:0] row_sum(input logic [63:0] gains,
			input logic [31:0] off, input rect_t r, input logic sx, input logic sy);
		logic signed [127:0] gx, gy, term_x, term_y, acc;
		gx = $signed(gains[63:32]);
		gy = $signed(gains[31:0]);
		term_x = gx * $signed(r.fw);
		term_y = gy * $signed(r.fh);
		acc = 2 * (gx * $signed(r.cx) + gy * $signed(r.cy));
		acc = acc + (sx ? term_x : -term_x) + (sy ? term_y : -term_y);
		acc = acc + $signed(off) * (128'sd1 <<< (FRAC_BITS_DEF + 1));
		return acc;
	endfunction

	// Corners behind the viewer are dropped; the box misses the square on a side
	// only when every kept corner lies strictly beyond it.
	function automatic cull_result_t predict_cull(input rect_t r);
		logic signed [127:0] w, x, y;
		logic sx, sy, all_l, all_r, all_b, all_a;
		int k, kept;
		cull_result_t res;
		kept = 0;
		all_l = 1'b1;
		all_r = 1'b1;
		all_b = 1'b1;
		all_a = 1'b1;
		for (k = 0; k < 4; k++) begin
			sx = (k == 1) || (k == 2);
			sy = (k >= 2);
			w = row_sum(mat_w_gains, mat_w_off, r, sx, sy);
			if (w > 0) begin
				x = row_sum(mat_x_gains, mat_x_off, r, sx, sy);
				y = row_sum(mat_y_gains, mat_y_off, r, sx, sy);
				kept++;
				if (x + w >= 0) all_l = 1'b0;
				if (w - x >= 0) all_r = 1'b0;
				if (y + w >= 0) all_b = 1'b0;
				if (w - y >= 0) all_a = 1'b0;
			end
		end
		res.visible  = (kept != 0) && !all_l && !all_r && !all_b && !all_a;
		res.in_front = kept[2:0];
		return res;
	endfunction

	function automatic dir_row_t seen_row(input logic [31:0] cx, cy, fw, fh,
			input logic vis, input logic [2:0] nf);
		dir_row_t row;
		row = '0;
		row.rect  = '{cx, cy, fw, fh};
		row.typed = 1'b1;
		row.want  = '{vis, nf};
		return row;
	endfunction

	function automatic dir_row_t pred_row(input logic [31:0] cx, cy, fw, fh);
		dir_row_t row;
		row = '0;
		row.rect = '{cx, cy, fw, fh};
		return row;
	endfunction

	function automatic dir_row_t write_row(input logic [2:0] idx, input logic [63:0] val);
		dir_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_val  = val;
		return row;
	endfunction

	// Uniform value in [-span, span].
	function automatic logic [31:0] rand_span(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return FX_MIN;
			1: return FX_MAX;
			2: return FX_ZERO;
			3: return FX_ONE;
			default: return FX_NEG1;
		endcase
	endfunction

	// Mostly rectangles near the view, some raw bit patterns and some extremes.
	function automatic rect_t draw_rect();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return '{rand_span(SPAN4), rand_span(SPAN4), rand_span(SPAN4), rand_span(SPAN4)};
		else if (k < 9)
			return '{$urandom, $urandom, $urandom, $urandom};
		return '{pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
	endfunction

	function automatic logic [63:0] pick_gains(input matrix_mode_t mode, input int span);
		case (mode)
			MX_SCENE:   return {rand_span(span), rand_span(span)};
			MX_EXTREME: return {pick_extreme(), pick_extreme()};
			default:    return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] pick_offset(input matrix_mode_t mode, input logic is_w);
		case (mode)
			MX_SCENE:   return is_w ? int'($urandom_range(0, 163840)) - 32768 : rand_span(65536);
			MX_EXTREME: return pick_extreme();
			default:    return $urandom;
		endcase
	endfunction

	// Register write: setup cycle, then access cycle; the predictor follows.
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_X_GAINS:  mat_x_gains = val;
			REG_X_OFFSET: mat_x_off   = val[31:0];
			REG_Y_GAINS:  mat_y_gains = val;
			REG_Y_OFFSET: mat_y_off   = val[31:0];
			REG_W_GAINS:  mat_w_gains = val;
			REG_W_OFFSET: mat_w_off   = val[31:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_culls.size() != 0) @(posedge clk);
	endtask

	// Offset registers also get random upper bits, which the block must ignore.
	task automatic load_matrix(input matrix_mode_t mode);
		wait_drained();
		if (mode == MX_RESET) begin
			reg_write(REG_X_GAINS,  X_GAINS_RST);
			reg_write(REG_X_OFFSET, {$urandom, X_OFFSET_RST});
			reg_write(REG_Y_GAINS,  Y_GAINS_RST);
			reg_write(REG_Y_OFFSET, {$urandom, Y_OFFSET_RST});
			reg_write(REG_W_GAINS,  W_GAINS_RST);
			reg_write(REG_W_OFFSET, {$urandom, W_OFFSET_RST});
		end else begin
			reg_write(REG_X_GAINS,  pick_gains(mode, 2 * 65536));
			reg_write(REG_X_OFFSET, {$urandom, pick_offset(mode, 1'b0)});
			reg_write(REG_Y_GAINS,  pick_gains(mode, 2 * 65536));
			reg_write(REG_Y_OFFSET, {$urandom, pick_offset(mode, 1'b0)});
			reg_write(REG_W_GAINS,  pick_gains(mode, 16384));
			reg_write(REG_W_OFFSET, {$urandom, pick_offset(mode, 1'b1)});
		end
	endtask

	// Offer one rectangle, with an occasional idle burst first, and queue its result.
	task automatic send_rect(input rect_t r, input cull_result_t want);
		if (tx_idling && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.fh, r.fw, r.cy, r.cx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_culls.push_back(want);
	endtask

	// Result side: check each accepted item and stall in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_culls.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item: visible=%0d in_front=%0d",
							m_tdata[0], m_tdata[3:1]);
					fail_count++;
				end else if (m_tdata[0] !== pending_culls[0].visible ||
						m_tdata[3:1] !== pending_culls[0].in_front) begin
					if (fail_count < 10)
						$display("mismatch: expected visible=%0d in_front=%0d, got visible=%0d in_front=%0d",
							pending_culls[0].visible, pending_culls[0].in_front,
							m_tdata[0], m_tdata[3:1]);
					fail_count++;
					void'(pending_culls.pop_front());
				end else begin
					void'(pending_culls.pop_front());
				end
			end
			if (stall_left != 0) begin
				m_tready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (rx_idling && $urandom_range(0, 5) == 0) begin
				m_tready   <= 1'b0;
				stall_left <= $urandom_range(0, 16);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which no item and no register access moves.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		matrix_mode_t modes[7];
		rect_t        r;
		int           i, phase, n;
		arst_n <= 1'b0;
		modes = '{MX_SCENE, MX_EXTREME, MX_NOISE, MX_SCENE, MX_NOISE, MX_SCENE, MX_RESET};

		// Under the reset matrix NDC equals world coordinates and every corner is in front.
		dir_table.push_back(seen_row(FX_ZERO, FX_ZERO, FX_ONE, FX_ONE, 1'b1, 3'd4));
		dir_table.push_back(seen_row(FX_MAX, FX_ZERO, FX_ZERO, FX_ZERO, 1'b0, 3'd4));
		dir_table.push_back(seen_row(FX_MIN, FX_ZERO, FX_ZERO, FX_ZERO, 1'b0, 3'd4));
		dir_table.push_back(seen_row(FX_ZERO, FX_MAX, FX_ZERO, FX_ZERO, 1'b0, 3'd4));
		dir_table.push_back(seen_row(FX_ZERO, FX_MIN, FX_ZERO, FX_ZERO, 1'b0, 3'd4));
		// A point exactly on an edge is inside; one step beyond is not.
		dir_table.push_back(seen_row(FX_ONE, FX_ZERO, FX_ZERO, FX_ZERO, 1'b1, 3'd4));
		dir_table.push_back(seen_row(FX_ONE + 1, FX_ZERO, FX_ZERO, FX_ZERO, 1'b0, 3'd4));
		dir_table.push_back(seen_row(FX_NEG1, FX_ZERO, FX_ZERO, FX_ZERO, 1'b1, 3'd4));
		dir_table.push_back(seen_row(FX_NEG1 - 1, FX_ZERO, FX_ZERO, FX_ZERO, 1'b0, 3'd4));
		dir_table.push_back(seen_row(FX_ZERO, FX_ONE, FX_ZERO, FX_ZERO, 1'b1, 3'd4));
		dir_table.push_back(seen_row(FX_ZERO, FX_NEG1, FX_ZERO, FX_ZERO, 1'b1, 3'd4));
		// Negative sizes only swap the corners.
		dir_table.push_back(seen_row(FX_ZERO, FX_ZERO, 32'hFFFE_0000, 32'hFFFE_0000,
			1'b1, 3'd4));
		dir_table.push_back(seen_row(FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0, 3'd4));
		dir_table.push_back(seen_row(FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0, 3'd4));
		dir_table.push_back(seen_row(FX_ZERO, FX_ZERO, FX_MIN, FX_MIN, 1'b1, 3'd4));
		dir_table.push_back(seen_row(32'h0003_0000, FX_ZERO, 32'h0008_0000, FX_ZERO,
			1'b1, 3'd4));
		dir_table.push_back(seen_row(32'h0005_0001, FX_ZERO, 32'h0008_0000, FX_ZERO,
			1'b0, 3'd4));
		// Every corner behind the viewer, then every corner with w of zero.
		dir_table.push_back(write_row(REG_W_OFFSET, {32'hA5A5_A5A5, FX_NEG1}));
		dir_table.push_back(seen_row(FX_ZERO, FX_ZERO, FX_ONE, FX_ONE, 1'b0, 3'd0));
		dir_table.push_back(write_row(REG_W_OFFSET, {32'hFFFF_FFFF, FX_ZERO}));
		dir_table.push_back(seen_row(FX_ZERO, FX_ZERO, FX_ONE, FX_ONE, 1'b0, 3'd0));
		// w follows x, so only some corners stay in front.
		dir_table.push_back(write_row(REG_W_GAINS, {FX_ONE, FX_ZERO}));
		dir_table.push_back(pred_row(FX_ZERO, FX_ZERO, 32'h0002_0000, 32'h0002_0000));
		dir_table.push_back(pred_row(FX_MAX, FX_MIN, FX_MAX, FX_MIN));
		// A write past the last register changes nothing.
		dir_table.push_back(write_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
		dir_table.push_back(pred_row(FX_ONE, FX_ONE, FX_ONE, FX_ONE));
		dir_table.push_back(write_row(REG_X_OFFSET, {32'h1234_5678, FX_MIN}));
		dir_table.push_back(write_row(REG_Y_GAINS, {FX_NEG1, FX_MAX}));
		dir_table.push_back(pred_row(32'h1234_5678, 32'hEDCB_A987, 32'h0000_8000,
			32'hFFFF_8000));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_table.size(); i++) begin
			if (dir_table[i].is_write) begin
				s_tvalid <= 1'b0;
				wait_drained();
				reg_write(dir_table[i].reg_idx, dir_table[i].reg_val);
			end else if (dir_table[i].typed) begin
				send_rect(dir_table[i].rect, dir_table[i].want);
			end else begin
				send_rect(dir_table[i].rect, predict_cull(dir_table[i].rect));
			end
		end

		// Random phases, each under its own matrix; the last one runs with no idling.
		for (phase = 0; phase < 7; phase++) begin
			s_tvalid <= 1'b0;
			load_matrix(modes[phase]);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 24 == 0) begin
					tx_idling = (phase != 6) && ($urandom_range(0, 3) != 0);
					rx_idling <= (phase != 6) && ($urandom_range(0, 3) != 0);
				end
				r = draw_rect();
				send_rect(r, predict_cull(r));
			end
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
